// ----- hdl/crcdf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcdf_pkg
// Shared constants and control types of the spline cdf integrator.
// ----------------------------------------------------------------------------
package crcdf_pkg;

    localparam int CDF_W      = 48;           // running integral, signed Q32.16
    localparam int SLOPE_QB   = 60;           // slope magnitude bits
    localparam int AREA_QB    = 47;           // segment area magnitude bits
    localparam int SLOPE_W    = SLOPE_QB + 1; // signed slope width
    localparam int INNER_W    = 63;           // signed width of the area bracket term
    localparam int AREA_DIV   = 12 * 65536;   // twelve, scaled back to Q16.16
    localparam int AREA_DIV_W = 20;

    localparam logic MODE_SLOPE = 1'b0;
    localparam logic MODE_AREA  = 1'b1;

    typedef struct packed {
        logic start;
        logic mode;
    } t_mdu_ctrl;

endpackage

// ----- hdl/crcdf_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcdf_in_if
// Node channel: position, function value and end-of-stream flag.
// ----------------------------------------------------------------------------
interface crcdf_in_if #(
    parameter int SAMPLE_WIDTH = 32
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_x;
    logic signed [SAMPLE_WIDTH-1:0] sample_f;
    logic                           last_node;

    modport source (output valid, output sample_x, output sample_f, output last_node,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_f, input last_node,
                    output ready);
endinterface

// ----- hdl/crcdf_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcdf_out_if
// Result channel: cdf entry with last and spacing error flags.
// ----------------------------------------------------------------------------
interface crcdf_out_if
    import crcdf_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [CDF_W-1:0] cdf_value;
    logic                    last_result;
    logic                    spacing_error;

    modport source (output valid, output cdf_value, output last_result,
                    output spacing_error, input ready);
    modport sink   (input valid, input cdf_value, input last_result,
                    input spacing_error, output ready);
endinterface

// ----- hdl/crcdf_muldiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcdf_muldiv
// Bit-serial round(a*b/d) with saturation: shift-add multiply one bit per
// cycle, then restoring division one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crcdf_muldiv
    import crcdf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mdu_ctrl                i_ctrl,
    input  logic signed [SAMPLE_WIDTH:0] i_a,
    input  logic signed [INNER_W-1:0]    i_b,
    input  logic signed [((SAMPLE_WIDTH > AREA_DIV_W) ? SAMPLE_WIDTH : AREA_DIV_W):0] i_d,
    output logic                     o_done,
    output logic signed [SLOPE_W-1:0] o_res
);

    localparam int AW    = SAMPLE_WIDTH;
    localparam int BW    = INNER_W - 1;
    localparam int PW    = AW + BW;
    localparam int NW    = PW + 1;
    localparam int DW    = (SAMPLE_WIDTH > AREA_DIV_W) ? SAMPLE_WIDTH : AREA_DIV_W;
    localparam int TW    = NW - AREA_QB;
    localparam int CMAX  = (AW > SLOPE_QB) ? AW : SLOPE_QB;
    localparam int CNT_W = $clog2(CMAX + 1);

    localparam logic [2:0] U_IDLE = 3'd0;
    localparam logic [2:0] U_MUL  = 3'd1;
    localparam logic [2:0] U_RND  = 3'd2;
    localparam logic [2:0] U_DIV  = 3'd3;
    localparam logic [2:0] U_FIN  = 3'd4;

    logic [2:0]          r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_mode;
    logic                r_neg;
    logic                r_ovf;
    logic [BW-1:0]       r_mb;
    logic [DW-1:0]       r_md;
    logic [PW-1:0]       r_p;
    logic [DW-1:0]       r_rem;
    logic [SLOPE_QB-1:0] r_nlo;
    logic [SLOPE_QB-1:0] r_q;
    logic                r_done;
    logic signed [SLOPE_W-1:0] r_res;

    logic [AW:0]         a_u, a_abs;
    logic [INNER_W-1:0]  b_u, b_abs;
    logic [DW:0]         d_u, d_abs;
    logic [BW:0]         m_sum;
    logic [PW-1:0]       n_p;
    logic [NW-1:0]       n_full;
    logic [TW-1:0]       n_top;
    logic                n_ovf;
    logic [SLOPE_QB-1:0] n_nlo;
    logic [DW:0]         rem2, rem_diff;
    logic                q_bit;
    logic [SLOPE_QB-1:0] lim, mag;

    assign a_u   = i_a;
    assign b_u   = i_b;
    assign d_u   = i_d;
    assign a_abs = a_u[AW] ? (~a_u + 1'b1) : a_u;
    assign b_abs = b_u[INNER_W-1] ? (~b_u + 1'b1) : b_u;
    assign d_abs = d_u[DW] ? (~d_u + 1'b1) : d_u;

    // multiply step, lsb of the multiplier sits at r_p[0]
    assign m_sum = {1'b0, r_p[PW-1:AW]} + (r_p[0] ? {1'b0, r_mb} : {(BW+1){1'b0}});
    assign n_p   = {m_sum, r_p[AW-1:1]};

    // add half the divisor for round to nearest, then check for quotient overflow
    assign n_full = {1'b0, r_p} + {{(NW-DW+1){1'b0}}, r_md[DW-1:1]};
    assign n_top  = (r_mode == MODE_AREA) ? n_full[NW-1:AREA_QB]
                  : {{(SLOPE_QB-AREA_QB){1'b0}}, n_full[NW-1:SLOPE_QB]};
    assign n_ovf  = n_top >= {{(TW-DW){1'b0}}, r_md};
    assign n_nlo  = (r_mode == MODE_AREA)
                  ? {n_full[AREA_QB-1:0], {(SLOPE_QB-AREA_QB){1'b0}}}
                  : n_full[SLOPE_QB-1:0];

    assign rem2     = {r_rem, r_nlo[SLOPE_QB-1]};
    assign rem_diff = rem2 - {1'b0, r_md};
    assign q_bit    = rem2 >= {1'b0, r_md};

    assign lim = (r_mode == MODE_AREA) ? {{(SLOPE_QB-AREA_QB){1'b0}}, {AREA_QB{1'b1}}}
                                       : {SLOPE_QB{1'b1}};
    assign mag = r_ovf ? lim : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                U_IDLE: begin
                    if (i_ctrl.start) begin
                        r_mode  <= i_ctrl.mode;
                        r_neg   <= a_u[AW] ^ b_u[INNER_W-1] ^ d_u[DW];
                        r_mb    <= b_abs[BW-1:0];
                        r_md    <= d_abs[DW-1:0];
                        r_p     <= {{BW{1'b0}}, a_abs[AW-1:0]};
                        r_cnt   <= CNT_W'(AW);
                        r_state <= U_MUL;
                    end
                end
                U_MUL: begin
                    r_p   <= n_p;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= U_RND;
                    end
                end
                U_RND: begin
                    r_rem   <= n_top[DW-1:0];
                    r_nlo   <= n_nlo;
                    r_q     <= '0;
                    r_ovf   <= n_ovf;
                    r_cnt   <= (r_mode == MODE_AREA) ? CNT_W'(AREA_QB) : CNT_W'(SLOPE_QB);
                    r_state <= n_ovf ? U_FIN : U_DIV;
                end
                U_DIV: begin
                    r_rem <= q_bit ? rem_diff[DW-1:0] : rem2[DW-1:0];
                    r_q   <= {r_q[SLOPE_QB-2:0], q_bit};
                    r_nlo <= {r_nlo[SLOPE_QB-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= U_FIN;
                    end
                end
                U_FIN: begin
                    r_res   <= r_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
                    r_done  <= 1'b1;
                    r_state <= U_IDLE;
                end
                default: begin
                    r_state <= U_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- hdl/catmull_rom_cdf_integrator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_cdf_integrator
// Streaming Catmull-Rom spline integrator producing a cumulative table.
// ----------------------------------------------------------------------------
// Nodes (x, f) in signed Q16.16 come in on i_node; the block keeps the last
// three nodes and a saturating Q32.16 running integral, and returns one cdf
// entry per spline segment on o_cdf (0 for the first node, the last node also
// closes the final segment and resets the stream). All segment arithmetic runs
// on one shared bit-serial multiply/divide unit, so one node is taken at a
// time. A segment needs up to two central slopes and one area on the unit, and
// a last node that closes two segments runs them one after the other; the first
// node of a stream, and a second node that is not the last, bypass the unit.
// A result waiting in the output register does not hold off the next node.
// ----------------------------------------------------------------------------
module catmull_rom_cdf_integrator
    import crcdf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    crcdf_in_if.sink     i_node,
    crcdf_out_if.source  o_cdf
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int DW = (SAMPLE_WIDTH > AREA_DIV_W) ? SAMPLE_WIDTH : AREA_DIV_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_D0   = 3'd1;
    localparam logic [2:0] S_D1   = 3'd2;
    localparam logic [2:0] S_AREA = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;

    logic [2:0]               r_state;
    logic signed [SW-1:0]     r_xc, r_fc;
    logic                     r_last;
    logic [1:0]               r_k;
    logic                     r_seg;      // 0: segment ending at newest stored node
    logic                     r_err;
    logic                     r_issued;
    logic signed [SLOPE_W-1:0] r_d0, r_d1;
    logic signed [CDF_W-1:0]  r_acc;
    logic signed [SW-1:0]     r_wx [3];
    logic signed [SW-1:0]     r_wf [3];
    logic [1:0]               r_cnt;
    logic                     r_ov;
    logic signed [CDF_W-1:0]  r_ocdf;
    logic                     r_olast;
    logic                     r_oerr;

    logic signed [SW-1:0]     xm, fm, x0, f0, x1, f1;
    logic                     hm, hp;
    logic signed [SW:0]       w, df, dfm, dxm, dfp, dxp;
    logic signed [63:0]       fsum, inner64;
    logic signed [INNER_W-1:0] b_sel;
    logic signed [DW:0]       d_sel;
    t_mdu_ctrl                mdu_ctrl;
    logic                     mdu_done;
    logic signed [SLOPE_W-1:0] mdu_res;
    logic signed [CDF_W-1:0]  area;
    logic signed [CDF_W:0]    acc_sum;
    logic signed [CDF_W-1:0]  n_acc;
    logic                     in_fire, slot_free, emit_last;

    // operands of the segment under work
    assign xm = r_seg ? r_wx[1] : r_wx[2];
    assign fm = r_seg ? r_wf[1] : r_wf[2];
    assign x0 = r_seg ? r_wx[0] : r_wx[1];
    assign f0 = r_seg ? r_wf[0] : r_wf[1];
    assign x1 = r_seg ? r_xc    : r_wx[0];
    assign f1 = r_seg ? r_fc    : r_wf[0];
    assign hm = r_seg ? r_k[1] : (r_k == 2'd3);
    assign hp = ~r_seg;

    assign w   = {x1[SW-1], x1} - {x0[SW-1], x0};
    assign df  = {f1[SW-1], f1} - {f0[SW-1], f0};
    assign dfm = {f1[SW-1], f1} - {fm[SW-1], fm};
    assign dxm = {x1[SW-1], x1} - {xm[SW-1], xm};
    assign dfp = {r_fc[SW-1], r_fc} - {f0[SW-1], f0};
    assign dxp = {r_xc[SW-1], r_xc} - {x0[SW-1], x0};

    // 6*(f0+f1) + d0 - d1
    assign fsum    = 64'(f0) + 64'(f1);
    assign inner64 = (fsum <<< 2) + (fsum <<< 1) + 64'(r_d0) - 64'(r_d1);

    always_comb begin
        b_sel = INNER_W'(inner64[INNER_W-1:0]);
        d_sel = (DW+1)'(AREA_DIV);
        mdu_ctrl.mode  = MODE_AREA;
        mdu_ctrl.start = 1'b0;
        unique case (r_state)
            S_D0: begin
                b_sel = INNER_W'(dfm);
                d_sel = (DW+1)'(dxm);
                mdu_ctrl.mode  = MODE_SLOPE;
                mdu_ctrl.start = !r_issued && hm && (dxm != '0);
            end
            S_D1: begin
                b_sel = INNER_W'(dfp);
                d_sel = (DW+1)'(dxp);
                mdu_ctrl.mode  = MODE_SLOPE;
                mdu_ctrl.start = !r_issued && hp && (dxp != '0);
            end
            S_AREA: begin
                mdu_ctrl.start = !r_issued;
            end
            default: begin
            end
        endcase
    end

    crcdf_muldiv #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mdu_ctrl),
        .i_a     (w),
        .i_b     (b_sel),
        .i_d     (d_sel),
        .o_done  (mdu_done),
        .o_res   (mdu_res)
    );

    // saturating accumulate of the segment area
    assign area    = mdu_res[CDF_W-1:0];
    assign acc_sum = (CDF_W+1)'(r_acc) + (CDF_W+1)'(area);
    assign n_acc   = (acc_sum[CDF_W] != acc_sum[CDF_W-1])
                   ? (acc_sum[CDF_W] ? {1'b1, {(CDF_W-1){1'b0}}} : {1'b0, {(CDF_W-1){1'b1}}})
                   : acc_sum[CDF_W-1:0];

    assign i_node.ready = (r_state == S_IDLE);
    assign in_fire      = i_node.valid && (r_state == S_IDLE);
    assign slot_free    = !r_ov || o_cdf.ready;
    assign emit_last    = (r_k == 2'd0) ? r_last : r_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_cnt    <= 2'd0;
            r_acc    <= '0;
            r_ov     <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_wx[i] <= '0;
                r_wf[i] <= '0;
            end
        end else begin
            if (o_cdf.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_xc     <= i_node.sample_x;
                        r_fc     <= i_node.sample_f;
                        r_last   <= i_node.last_node;
                        r_k      <= r_cnt;
                        r_seg    <= (r_cnt == 2'd1);
                        r_err    <= 1'b0;
                        r_issued <= 1'b0;
                        if (r_cnt == 2'd0) begin
                            r_acc   <= '0;
                            r_state <= S_EMIT;
                        end else if (r_cnt == 2'd1 && !i_node.last_node) begin
                            r_state <= S_UPD;
                        end else begin
                            r_state <= S_D0;
                        end
                    end
                end
                S_D0: begin
                    if (!hm) begin
                        r_d0    <= SLOPE_W'(df);
                        r_state <= S_D1;
                    end else if (dxm == '0) begin
                        r_d0    <= '0;
                        r_err   <= 1'b1;
                        r_state <= S_D1;
                    end else if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (mdu_done) begin
                        r_d0     <= mdu_res;
                        r_issued <= 1'b0;
                        r_state  <= S_D1;
                    end
                end
                S_D1: begin
                    if (!hp) begin
                        r_d1    <= SLOPE_W'(df);
                        r_state <= S_AREA;
                    end else if (dxp == '0) begin
                        r_d1    <= '0;
                        r_err   <= 1'b1;
                        r_state <= S_AREA;
                    end else if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (mdu_done) begin
                        r_d1     <= mdu_res;
                        r_issued <= 1'b0;
                        r_state  <= S_AREA;
                    end
                end
                S_AREA: begin
                    if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (mdu_done) begin
                        r_acc    <= n_acc;
                        r_issued <= 1'b0;
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_ov    <= 1'b1;
                        r_ocdf  <= r_acc;
                        r_olast <= emit_last;
                        r_oerr  <= r_err;
                        // a last node also closes the segment ending at itself
                        if (r_k != 2'd0 && !r_seg && r_last) begin
                            r_seg   <= 1'b1;
                            r_err   <= 1'b0;
                            r_state <= S_D0;
                        end else begin
                            r_state <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    if (r_last) begin
                        r_cnt <= 2'd0;
                        r_acc <= '0;
                        for (int i = 0; i < 3; i++) begin
                            r_wx[i] <= '0;
                            r_wf[i] <= '0;
                        end
                    end else begin
                        r_wx[2] <= r_wx[1];
                        r_wf[2] <= r_wf[1];
                        r_wx[1] <= r_wx[0];
                        r_wf[1] <= r_wf[0];
                        r_wx[0] <= r_xc;
                        r_wf[0] <= r_fc;
                        if (r_cnt != 2'd3) begin
                            r_cnt <= r_cnt + 2'd1;
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cdf.valid         = r_ov;
    assign o_cdf.cdf_value     = r_ocdf;
    assign o_cdf.last_result   = r_olast;
    assign o_cdf.spacing_error = r_oerr;

endmodule
